>>> rtl/cfd_pkg.sv
// ----------------------------------------------------------------------------
// cfd_pkg: shared types and constants for the CAN frame deframer
// Frame layout constants, the queued frame record and the checksum function.
// ----------------------------------------------------------------------------
package cfd_pkg;

  localparam logic [3:0] FrameLast  = 4'd15;
  localparam logic [3:0] IdLast     = 4'd3;
  localparam logic [3:0] ExtPos     = 4'd4;
  localparam logic [3:0] RtrPos     = 4'd5;
  localparam logic [3:0] LenPos     = 4'd6;
  localparam logic [7:0] ByteMask   = 8'hff;
  localparam logic [7:0] MaxLen     = 8'd8;
  localparam int         DataBytes  = 8;
  localparam int         QueueDepth = 2;

  typedef struct packed {
    logic [11:0] sum;
    logic [7:0]  cks;
    logic [31:0] id;
    logic        ext;
    logic        rtr;
    logic [7:0]  len;
    logic [63:0] payload;
  } rec_t;

  function automatic logic [7:0] checksum_of(input logic [11:0] sum);
    logic [11:0] neg;
    neg = ~sum + 12'd1;
    if (sum > {4'd0, ByteMask}) begin
      checksum_of = neg[7:0];
    end else begin
      checksum_of = sum[7:0];
    end
  endfunction

endpackage

>>> rtl/cfd_if.sv
// ----------------------------------------------------------------------------
// cfd_in_if / cfd_out_if: valid/ready channels of the deframer
// Byte input channel and frame result channel.
// ----------------------------------------------------------------------------
interface cfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] raw_byte;
  logic       start_of_frame;

  modport source (output valid, output raw_byte, output start_of_frame, input ready);
  modport sink   (input valid, input raw_byte, input start_of_frame, output ready);
endinterface

interface cfd_out_if;
  logic        valid;
  logic        ready;
  logic        frame_ok;
  logic [31:0] frame_id;
  logic        extended_flag;
  logic        remote_flag;
  logic [3:0]  data_length;
  logic        length_error;
  logic [63:0] data_bytes;

  modport source (output valid, output frame_ok, output frame_id, output extended_flag,
                  output remote_flag, output data_length, output length_error,
                  output data_bytes, input ready);
  modport sink   (input valid, input frame_ok, input frame_id, input extended_flag,
                  input remote_flag, input data_length, input length_error,
                  input data_bytes, output ready);
endinterface

>>> rtl/cfd_front.sv
// ----------------------------------------------------------------------------
// cfd_front: byte intake and frame assembly
// Tracks byte position, accumulates the frame fields and pushes one record
// to the queue when the checksum byte arrives.
// ----------------------------------------------------------------------------
module cfd_front
  import cfd_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  cfd_in_if.sink in_ch,
  input  logic   q_full,
  output logic   q_push,
  output rec_t   q_rec
);

  logic [3:0]  pos_r, pos_nxt;
  logic [11:0] sum_r, sum_nxt;
  logic [31:0] id_r, id_nxt;
  logic        ext_r, ext_nxt;
  logic        rtr_r, rtr_nxt;
  logic [7:0]  len_r, len_nxt;
  logic [63:0] pay_r, pay_nxt;

  logic       xfer;
  logic [3:0] pos;
  logic [2:0] lane;

  assign in_ch.ready = ~q_full;
  assign xfer        = in_ch.valid & in_ch.ready;
  assign pos         = in_ch.start_of_frame ? 4'd0 : pos_r;
  assign lane        = pos[2:0] + 3'd1;

  always_comb begin
    pos_nxt = pos_r;
    sum_nxt = sum_r;
    id_nxt  = id_r;
    ext_nxt = ext_r;
    rtr_nxt = rtr_r;
    len_nxt = len_r;
    pay_nxt = pay_r;
    q_push  = 1'b0;
    if (xfer) begin
      if (pos == 4'd0) begin
        sum_nxt = '0;
        id_nxt  = '0;
        ext_nxt = 1'b0;
        rtr_nxt = 1'b0;
        len_nxt = '0;
        pay_nxt = '0;
      end
      if (pos == FrameLast) begin
        q_push  = 1'b1;
        pos_nxt = 4'd0;
      end else begin
        sum_nxt = sum_nxt + {4'd0, in_ch.raw_byte};
        pos_nxt = pos + 4'd1;
        if (pos <= IdLast) begin
          id_nxt = {id_nxt[23:0], in_ch.raw_byte};
        end else if (pos == ExtPos) begin
          ext_nxt = |in_ch.raw_byte;
        end else if (pos == RtrPos) begin
          rtr_nxt = |in_ch.raw_byte;
        end else if (pos == LenPos) begin
          len_nxt = in_ch.raw_byte;
        end else begin
          pay_nxt[8*lane +: 8] = in_ch.raw_byte;
        end
      end
    end
  end

  always_comb begin
    q_rec.sum     = sum_r;
    q_rec.cks     = in_ch.raw_byte;
    q_rec.id      = id_r;
    q_rec.ext     = ext_r;
    q_rec.rtr     = rtr_r;
    q_rec.len     = len_r;
    q_rec.payload = pay_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else begin
      pos_r <= pos_nxt;
    end
    sum_r <= sum_nxt;
    id_r  <= id_nxt;
    ext_r <= ext_nxt;
    rtr_r <= rtr_nxt;
    len_r <= len_nxt;
    pay_r <= pay_nxt;
  end

endmodule

>>> rtl/cfd_queue.sv
// ----------------------------------------------------------------------------
// cfd_queue: frame record queue
// Small FIFO between frame assembly and result formatting.
// ----------------------------------------------------------------------------
module cfd_queue
  import cfd_pkg::*;
#(
  parameter int Depth = QueueDepth
)
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  rec_t push_rec,
  output logic full,
  input  logic pop,
  output logic not_empty,
  output rec_t pop_rec
);

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);

  rec_t            mem_r [Depth];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            do_push, do_pop;

  assign full      = (cnt_r == CntW'(Depth));
  assign not_empty = (cnt_r != '0);
  assign do_push   = push & ~full;
  assign do_pop    = pop & not_empty;
  assign pop_rec   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrLast) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrLast) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_rec;
    end
  end

endmodule

>>> rtl/cfd_back.sv
// ----------------------------------------------------------------------------
// cfd_back: checksum check and result formatting
// Pops frame records, checks the checksum, clamps the length, masks the
// payload and holds the result in the output register.
// ----------------------------------------------------------------------------
module cfd_back
  import cfd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_not_empty,
  input  rec_t       q_rec,
  output logic       q_pop,
  cfd_out_if.source  out_ch
);

  logic        valid_r, valid_nxt;
  logic        ok_r;
  logic [31:0] id_r;
  logic        ext_r;
  logic        rtr_r;
  logic [3:0]  len_r;
  logic        lerr_r;
  logic [63:0] data_r;

  logic        ok;
  logic        over;
  logic [3:0]  len_c;
  logic [63:0] data_c;

  assign q_pop     = q_not_empty & (~valid_r | out_ch.ready);
  assign valid_nxt = q_pop | (valid_r & ~out_ch.ready);

  assign ok    = (checksum_of(q_rec.sum) == q_rec.cks);
  assign over  = (q_rec.len > MaxLen);
  assign len_c = over ? MaxLen[3:0] : q_rec.len[3:0];

  always_comb begin
    data_c = q_rec.payload;
    for (int i = 0; i < DataBytes; i++) begin
      if (4'(i) >= len_c) begin
        data_c[8*i +: 8] = 8'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    if (q_pop) begin
      ok_r   <= ok;
      id_r   <= ok ? q_rec.id : '0;
      ext_r  <= ok & q_rec.ext;
      rtr_r  <= ok & q_rec.rtr;
      len_r  <= ok ? len_c : '0;
      lerr_r <= ok & over;
      data_r <= ok ? data_c : '0;
    end
  end

  assign out_ch.valid         = valid_r;
  assign out_ch.frame_ok      = ok_r;
  assign out_ch.frame_id      = id_r;
  assign out_ch.extended_flag = ext_r;
  assign out_ch.remote_flag   = rtr_r;
  assign out_ch.data_length   = len_r;
  assign out_ch.length_error  = lerr_r;
  assign out_ch.data_bytes    = data_r;

endmodule

>>> rtl/can_frame_deframer.sv
// ----------------------------------------------------------------------------
// can_frame_deframer: 16-byte CAN frame record deframer
// Reassembles frame records from a byte stream and emits one checked result
// per frame.
//
// in_ch takes one byte per transfer; start_of_frame realigns the byte to
// position 0 and drops any partial frame. Without a marker the position wraps
// after byte 15. Bytes 0-14 cost no result; byte 15 (checksum) yields one.
// Throughput: one byte per cycle sustained while the queue is not full.
// The result of a frame passes through the queue and then the output register
// before it is valid on out_ch.
// A failed checksum gives frame_ok = 0 with all other fields zero.
// When out_ch stalls, results collect in the QUEUE_DEPTH-entry queue; in_ch
// drops ready only while that queue is full.
// Reset (rst_n low, synchronous) empties the queue and output register and
// returns the byte position to 0. QUEUE_DEPTH must be 2 or more.
// ----------------------------------------------------------------------------
module can_frame_deframer
  import cfd_pkg::*;
#(
  parameter int QUEUE_DEPTH = QueueDepth
)
(
  input  logic      clk,
  input  logic      rst_n,
  cfd_in_if.sink    in_ch,
  cfd_out_if.source out_ch
);

  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_not_empty;
  rec_t push_rec;
  rec_t pop_rec;

  cfd_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_rec   (push_rec)
  );

  cfd_queue #(
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_rec  (push_rec),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_rec   (pop_rec)
  );

  cfd_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_rec       (pop_rec),
    .q_pop       (q_pop),
    .out_ch      (out_ch)
  );

endmodule

>>> tb/can_frame_deframer_test.sv
// ----------------------------------------------------------------------------
// can_frame_deframer_test: self-checking bench for the CAN frame deframer
// Drives frame bytes over in_ch and predicts each frame result from its own
// deframing model. Results on out_ch are compared field by field in order.
// A short directed table comes first, then random frames, partial frames and
// stray bytes under several sender and receiver idling patterns.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module can_frame_deframer_test;
  import cfd_pkg::*;

  localparam int DataFirst    = 7;
  localparam int PhaseItems   = 279;
  localparam int LongHold     = 400;
  localparam int SettleCycles = 20;
  localparam int CycleLimit   = 200000;
  localparam int MaxReports   = 50;
  localparam int SendIdlePct [4] = '{0, 64, 0, 15};
  localparam int RecvStallPct[4] = '{0, 0, 64, 15};

  typedef struct packed {
    logic        frame_ok;
    logic [31:0] frame_id;
    logic        extended_flag;
    logic        remote_flag;
    logic [3:0]  data_length;
    logic        length_error;
    logic [63:0] data_bytes;
  } frame_result_t;

  typedef struct packed {
    logic [4:0]    count;
    logic          sof;
    logic [7:0]    raw;
    logic          typed;
    frame_result_t want;
  } directed_row_t;

  // checksum mismatch clears every field
  localparam frame_result_t NoMatchFrame = '0;
  localparam frame_result_t AllOnesFrame = '{frame_ok: 1'b1, frame_id: 32'hFFFF_FFFF,
                                             extended_flag: 1'b1, remote_flag: 1'b1,
                                             data_length: 4'd8, length_error: 1'b1,
                                             data_bytes: 64'hFFFF_FFFF_FFFF_FFFF};

  // all-ones frame: sum above 255, length clamped; then a zero frame that
  // follows without a marker and carries a wrong checksum
  localparam directed_row_t DirectedRows[7] = '{
    '{5'd1,  1'b1, 8'hFF, 1'b0, NoMatchFrame},
    '{5'd1,  1'b0, 8'hFF, 1'b0, NoMatchFrame},
    '{5'd1,  1'b1, 8'hFF, 1'b0, NoMatchFrame},
    '{5'd14, 1'b0, 8'hFF, 1'b0, NoMatchFrame},
    '{5'd1,  1'b0, 8'h0F, 1'b1, AllOnesFrame},
    '{5'd15, 1'b0, 8'h00, 1'b0, NoMatchFrame},
    '{5'd1,  1'b0, 8'h01, 1'b1, NoMatchFrame}
  };

  logic clk;
  logic rst_n;

  cfd_in_if  in_ch();
  cfd_out_if out_ch();

  can_frame_deframer i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  frame_result_t expected_results[$];

  logic [3:0]  frm_pos     = '0;
  logic [11:0] frm_sum     = '0;
  logic [31:0] frm_id      = '0;
  logic        frm_ext     = 1'b0;
  logic        frm_rtr     = 1'b0;
  logic [7:0]  frm_len     = '0;
  logic [63:0] frm_payload = '0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int recv_hold_left = 0;
  int phase_bytes = 0;
  int error_count = 0;
  int cycle_count = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report(input string msg);
    if (error_count < MaxReports) begin
      $display("%0t: %s", $time, msg);
    end
    error_count++;
  endtask

  task automatic deframe_byte(input logic [7:0] b, input logic sof,
                              output bit produced, output frame_result_t res);
    logic [11:0] neg;
    logic [7:0]  cks;
    logic [7:0]  len;
    produced = 1'b0;
    res = '0;
    if (sof) begin
      frm_pos = '0;
    end
    if (frm_pos == '0) begin
      frm_sum = '0;
      frm_id = '0;
      frm_ext = 1'b0;
      frm_rtr = 1'b0;
      frm_len = '0;
      frm_payload = '0;
    end
    if (frm_pos != FrameLast) begin
      frm_sum = frm_sum + 12'(b);
      if (frm_pos <= IdLast) begin
        frm_id = {frm_id[23:0], b};
      end else if (frm_pos == ExtPos) begin
        frm_ext = (b != 8'd0);
      end else if (frm_pos == RtrPos) begin
        frm_rtr = (b != 8'd0);
      end else if (frm_pos == LenPos) begin
        frm_len = b;
      end else begin
        frm_payload[8 * (int'(frm_pos) - DataFirst) +: 8] = b;
      end
      frm_pos = frm_pos + 4'd1;
    end else begin
      produced = 1'b1;
      frm_pos = '0;
      neg = 12'd0 - frm_sum;
      cks = (frm_sum > 12'(ByteMask)) ? neg[7:0] : frm_sum[7:0];
      if (cks == b) begin
        len = (frm_len > MaxLen) ? MaxLen : frm_len;
        res.frame_ok = 1'b1;
        res.frame_id = frm_id;
        res.extended_flag = frm_ext;
        res.remote_flag = frm_rtr;
        res.data_length = len[3:0];
        res.length_error = (frm_len > MaxLen);
        for (int i = 0; i < DataBytes; i++) begin
          if (i < int'(len)) begin
            res.data_bytes[8 * i +: 8] = frm_payload[8 * i +: 8];
          end
        end
      end
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input logic sof, input logic typed,
                           input frame_result_t want);
    bit            produced;
    frame_result_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.raw_byte <= b;
    in_ch.start_of_frame <= sof;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    deframe_byte(b, sof, produced, res);
    if (produced) begin
      expected_results.push_back(typed ? want : res);
    end
    phase_bytes++;
  endtask

  task automatic send_random_unit();
    logic [7:0]  frame_bytes[16];
    logic [11:0] total;
    logic [11:0] neg;
    int          kind;
    int          mode;
    int          stop;
    bit          marker;
    kind = $urandom_range(99);
    if (kind < 5) begin
      send_byte(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b0, NoMatchFrame);
      return;
    end
    mode = $urandom_range(3);
    total = '0;
    for (int i = 0; i < 15; i++) begin
      case (mode)
        0: frame_bytes[i] = 8'($urandom_range(255));
        1: frame_bytes[i] = ($urandom_range(3) == 0) ? 8'($urandom_range(15)) : 8'd0;
        2: frame_bytes[i] = 8'($urandom_range(255));
        default: frame_bytes[i] = $urandom_range(1) ? 8'hFF : 8'h00;
      endcase
    end
    if (mode == 2) begin
      frame_bytes[ExtPos] = $urandom_range(1) ? 8'd0 : 8'($urandom_range(255));
      frame_bytes[RtrPos] = $urandom_range(1) ? 8'd0 : 8'($urandom_range(255));
      frame_bytes[LenPos] = ($urandom_range(9) == 0) ? 8'($urandom_range(255, 9))
                                                      : 8'($urandom_range(8));
    end
    for (int i = 0; i < 15; i++) begin
      total = total + 12'(frame_bytes[i]);
    end
    neg = 12'd0 - total;
    frame_bytes[15] = (total > 12'(ByteMask)) ? neg[7:0] : total[7:0];
    if ($urandom_range(7) == 0) begin
      frame_bytes[15] = frame_bytes[15] ^ 8'($urandom_range(255, 1));
    end
    stop = (kind < 15) ? $urandom_range(15, 1) : 16;
    marker = (frm_pos != '0) ? ($urandom_range(9) != 0) : 1'($urandom_range(1));
    for (int i = 0; i < stop; i++) begin
      send_byte(frame_bytes[i], (i == 0) && marker, 1'b0, NoMatchFrame);
    end
  endtask

  task automatic wait_for_results();
    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic check_result();
    frame_result_t got;
    frame_result_t want;
    got = '{frame_ok: out_ch.frame_ok, frame_id: out_ch.frame_id,
            extended_flag: out_ch.extended_flag, remote_flag: out_ch.remote_flag,
            data_length: out_ch.data_length, length_error: out_ch.length_error,
            data_bytes: out_ch.data_bytes};
    if (expected_results.size() == 0) begin
      report($sformatf("result with none expected, got %h", got));
      return;
    end
    want = expected_results.pop_front();
    if (got.frame_ok !== want.frame_ok)
      report($sformatf("frame_ok expected %0h, got %0h", want.frame_ok, got.frame_ok));
    if (got.frame_id !== want.frame_id)
      report($sformatf("frame_id expected %h, got %h", want.frame_id, got.frame_id));
    if (got.extended_flag !== want.extended_flag)
      report($sformatf("extended_flag expected %0h, got %0h",
                       want.extended_flag, got.extended_flag));
    if (got.remote_flag !== want.remote_flag)
      report($sformatf("remote_flag expected %0h, got %0h",
                       want.remote_flag, got.remote_flag));
    if (got.data_length !== want.data_length)
      report($sformatf("data_length expected %0h, got %0h",
                       want.data_length, got.data_length));
    if (got.length_error !== want.length_error)
      report($sformatf("length_error expected %0h, got %0h",
                       want.length_error, got.length_error));
    if (got.data_bytes !== want.data_bytes)
      report($sformatf("data_bytes expected %h, got %h", want.data_bytes, got.data_bytes));
  endtask

  // result side: ready, with long holds counted here
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (recv_hold_left > 0) begin
        out_ch.ready <= 1'b0;
        recv_hold_left--;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        check_result();
      end
    end
  end

  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    in_ch.valid <= 1'b0;
    in_ch.raw_byte <= '0;
    in_ch.start_of_frame <= 1'b0;
    rst_n <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (DirectedRows[r]) begin
      for (int k = 0; k < int'(DirectedRows[r].count); k++) begin
        send_byte(DirectedRows[r].raw, DirectedRows[r].sof,
                  DirectedRows[r].typed && (k == int'(DirectedRows[r].count) - 1),
                  DirectedRows[r].want);
      end
    end
    wait_for_results();

    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct = SendIdlePct[phase];
      recv_stall_pct = RecvStallPct[phase];
      phase_bytes = 0;
      // output held off while bytes keep coming: queue fills, in_ch stalls
      if (phase == 0) begin
        recv_hold_left = LongHold;
      end
      while (phase_bytes < PhaseItems) begin
        send_random_unit();
      end
      wait_for_results();
    end

    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
